// File: rtl/core/ftet_pkg.sv
// Package for the frame timer event table: request, result and slot record
// types, command and result codes, and controller states. No dependencies.
package ftet_pkg;

   localparam int SLOTS_DEF = 16;
   localparam logic [4:0] MAX_RES = 5'd16;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_SET    = 2'd3;

   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_ADD_OK = 2'd1;
   localparam logic [1:0] KIND_FULL   = 2'd2;

   localparam logic [1:0] HND_NORMAL = 2'd0;
   localparam logic [1:0] HND_START  = 2'd1;
   localparam logic [1:0] HND_END    = 2'd2;

   localparam int FL_ACTIVE = 0;
   localparam int FL_SKIP   = 1;
   localparam int FL_FRAME  = 2;
   localparam int FL_START  = 3;
   localparam int FL_END    = 4;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_ms;
      logic [31:0] frame_length;
      logic [15:0] frame_count;
      logic [31:0] init_delay;
      logic        skip_missed;
      logic        has_frame_handler;
      logic        has_start_handler;
      logic        has_end_handler;
      logic [15:0] target_id;
      logic        make_active;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] event_id;
      logic [15:0] frame_number;
      logic [1:0]  handler;
      logic        last;
   } res_type;

   typedef struct packed {
      logic [15:0] ident;
      logic [31:0] due;
      logic [31:0] pause_left;
      logic [15:0] frame;
      logic [31:0] length;
      logic [15:0] total;
      logic [4:0]  flags;
   } rec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORD,
      ST_REC,
      ST_EVAL,
      ST_SKIP,
      ST_WB,
      ST_FLUSH,
      ST_ADD_POP,
      ST_ADD_TAKE,
      ST_ADD_WR,
      ST_SHIFT_RD,
      ST_SHIFT_WR
   } state_type;

endpackage

// File: rtl/core/frame_timer_event_table.sv
// Frame timer event table top level: stream ports, output register, slot
// record, order and free-slot RAMs. Depends on ftet_pkg, ftet_ram, ftet_ctrl.
// Add: takes a never-used slot or pops the free-slot list, then writes the
// record. Remove and set active: search the order list entry by entry; a remove then shifts the later order entries.
// Tick: visits every live entry, steps a due entry that skips through its missed
// frames, and waits on result stalls. One request at a time.
// Reset: synchronous; table empty, ids start at 1, no clearing pass.
module frame_timer_event_table
   import ftet_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // now_ms, frame_length, frame_count, init_delay, skip_missed,
   // has_frame_handler, has_start_handler, has_end_handler, target_id,
   // make_active, zero fill
   input  logic [135:0] req_tdata,
   // command
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // event_id, frame_number
   output logic [31:0]  rsp_tdata,
   // kind, handler
   output logic [3:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   req_type       req_data;
   res_type       res_data, rsp_ff;
   logic          res_valid, res_ready, rsp_valid_ff;
   logic          o_we, r_we, f_we;
   logic [SW-1:0] o_waddr, o_wdata, o_raddr, o_rdata;
   logic [SW-1:0] r_waddr, r_raddr, f_waddr, f_wdata, f_raddr, f_rdata;
   rec_type       r_wdata, r_rdata;

   assign req_data.command           = req_tuser;
   assign req_data.now_ms            = req_tdata[31:0];
   assign req_data.frame_length      = req_tdata[63:32];
   assign req_data.frame_count       = req_tdata[79:64];
   assign req_data.init_delay        = req_tdata[111:80];
   assign req_data.skip_missed       = req_tdata[112];
   assign req_data.has_frame_handler = req_tdata[113];
   assign req_data.has_start_handler = req_tdata[114];
   assign req_data.has_end_handler   = req_tdata[115];
   assign req_data.target_id         = req_tdata[131:116];
   assign req_data.make_active       = req_tdata[132];

   assign res_ready = !rsp_valid_ff || rsp_tready;

   ftet_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_data  (req_data),
      .req_ready (req_tready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready),
      .o_we      (o_we),
      .o_waddr   (o_waddr),
      .o_wdata   (o_wdata),
      .o_raddr   (o_raddr),
      .o_rdata   (o_rdata),
      .r_we      (r_we),
      .r_waddr   (r_waddr),
      .r_wdata   (r_wdata),
      .r_raddr   (r_raddr),
      .r_rdata   (r_rdata),
      .f_we      (f_we),
      .f_waddr   (f_waddr),
      .f_wdata   (f_wdata),
      .f_raddr   (f_raddr),
      .f_rdata   (f_rdata)
   );

   ftet_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_order_ram (
      .clock (clock),
      .we    (o_we),
      .waddr (o_waddr),
      .wdata (o_wdata),
      .raddr (o_raddr),
      .rdata (o_rdata)
   );

   ftet_ram #(.WIDTH($bits(rec_type)), .DEPTH(SLOTS)) u_rec_ram (
      .clock (clock),
      .we    (r_we),
      .waddr (r_waddr),
      .wdata (r_wdata),
      .raddr (r_raddr),
      .rdata (r_rdata)
   );

   ftet_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.frame_number, rsp_ff.event_id};
   assign rsp_tuser  = {rsp_ff.handler, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.last;

endmodule

// File: rtl/core/ftet_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ftet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/core/ftet_ctrl.sv
// Controller of the frame timer event table: walks the order list, updates
// slot records in RAM and queues results. Depends on ftet_pkg.
module ftet_ctrl
   import ftet_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CW = $clog2(SLOTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_type       req_data,
   output logic          req_ready,
   output logic          res_valid,
   output res_type       res_data,
   input  logic          res_ready,
   output logic          o_we,
   output logic [SW-1:0] o_waddr,
   output logic [SW-1:0] o_wdata,
   output logic [SW-1:0] o_raddr,
   input  logic [SW-1:0] o_rdata,
   output logic          r_we,
   output logic [SW-1:0] r_waddr,
   output rec_type       r_wdata,
   output logic [SW-1:0] r_raddr,
   input  rec_type       r_rdata,
   output logic          f_we,
   output logic [SW-1:0] f_waddr,
   output logic [SW-1:0] f_wdata,
   output logic [SW-1:0] f_raddr,
   input  logic [SW-1:0] f_rdata
);

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] k_ff, k_in, w_ff, w_in, count_ff, count_in;
   logic [CW-1:0] fresh_ff, fresh_in, sp_ff, sp_in;
   logic [15:0]   id_ff, id_in;
   logic [SW-1:0] slot_ff, slot_in;
   rec_type       rec_ff, rec_in, rec_set;
   logic [4:0]    n_ff, n_in;
   logic          pend_valid_ff, pend_valid_in;
   res_type       pend_ff, pend_in;

   logic          elig, h_ok, emit, k_last;
   logic [1:0]    h_sel;
   logic [15:0]   fr_inc;
   logic [CW-1:0] k_p1, sp_m1;

   assign k_p1   = k_ff + CW'(1);
   assign sp_m1  = sp_ff - CW'(1);
   assign k_last = (k_p1 == count_ff);

   always_comb begin
      elig = r_rdata.flags[FL_ACTIVE] && (r_rdata.frame < r_rdata.total)
             && (req_ff.now_ms > r_rdata.due);
      h_ok  = 1'b1;
      h_sel = HND_NORMAL;
      if (r_rdata.flags[FL_START] && r_rdata.frame == 16'd0) begin
         h_sel = HND_START;
      end else if (r_rdata.flags[FL_END] && (17'(r_rdata.frame) + 17'd1) == 17'(r_rdata.total))
      begin
         h_sel = HND_END;
      end else if (!r_rdata.flags[FL_FRAME]) begin
         h_ok = 1'b0;
      end
      fr_inc = r_rdata.frame + 16'(h_ok);
      emit   = elig && h_ok && (n_ff < MAX_RES);
      rec_set = r_rdata;
      if (req_ff.make_active) begin
         rec_set.flags[FL_ACTIVE] = 1'b1;
         rec_set.due = req_ff.now_ms + r_rdata.pause_left;
      end else begin
         rec_set.flags[FL_ACTIVE] = 1'b0;
         rec_set.pause_left = (req_ff.now_ms > r_rdata.due) ? 32'd0
                              : r_rdata.due - req_ff.now_ms;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      k_in          = k_ff;
      w_in          = w_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      sp_in         = sp_ff;
      id_in         = id_ff;
      slot_in       = slot_ff;
      rec_in        = rec_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      res_data      = pend_ff;
      o_we          = 1'b0;
      o_waddr       = w_ff[SW-1:0];
      o_wdata       = slot_ff;
      o_raddr       = k_ff[SW-1:0];
      r_we          = 1'b0;
      r_waddr       = slot_ff;
      r_wdata       = rec_ff;
      r_raddr       = slot_ff;
      f_we          = 1'b0;
      f_waddr       = sp_ff[SW-1:0];
      f_wdata       = slot_ff;
      f_raddr       = sp_m1[SW-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               k_in   = '0;
               w_in   = '0;
               n_in   = '0;
               case (req_data.command)
                  CMD_TICK: begin
                     state_in = (count_ff == '0) ? ST_FLUSH : ST_ORD;
                  end
                  CMD_ADD: begin
                     if (count_ff == CW'(SLOTS)) begin
                        pend_in       = '{KIND_FULL, 16'd0, 16'd0, HND_NORMAL, 1'b0};
                        pend_valid_in = 1'b1;
                        state_in      = ST_FLUSH;
                     end else if (fresh_ff < CW'(SLOTS)) begin
                        slot_in  = fresh_ff[SW-1:0];
                        fresh_in = fresh_ff + CW'(1);
                        state_in = ST_ADD_WR;
                     end else begin
                        state_in = ST_ADD_POP;
                     end
                  end
                  CMD_REMOVE: begin
                     k_in     = count_ff - CW'(1);
                     state_in = (count_ff == '0) ? ST_IDLE : ST_ORD;
                  end
                  default: begin
                     state_in = (count_ff == '0) ? ST_IDLE : ST_ORD;
                  end
               endcase
            end
         end
         ST_ORD: begin
            state_in = ST_REC;
         end
         ST_REC: begin
            slot_in  = o_rdata;
            r_raddr  = o_rdata;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            case (req_ff.command)
               CMD_TICK: begin
                  if (!(emit && pend_valid_ff && !res_ready)) begin
                     if (emit) begin
                        res_valid     = pend_valid_ff;
                        pend_in       = '{KIND_FRAME, r_rdata.ident, fr_inc, h_sel, 1'b0};
                        pend_valid_in = 1'b1;
                        n_in          = n_ff + 5'd1;
                     end
                     rec_in = r_rdata;
                     if (elig) begin
                        rec_in.frame = fr_inc;
                        rec_in.due   = r_rdata.due + r_rdata.length;
                     end
                     state_in = (elig && r_rdata.flags[FL_SKIP]) ? ST_SKIP : ST_WB;
                  end
               end
               CMD_REMOVE: begin
                  if (r_rdata.ident == req_ff.target_id) begin
                     f_we     = 1'b1;
                     sp_in    = sp_ff + CW'(1);
                     count_in = count_ff - CW'(1);
                     state_in = (k_ff < count_in) ? ST_SHIFT_RD : ST_IDLE;
                  end else if (k_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     k_in     = k_ff - CW'(1);
                     state_in = ST_ORD;
                  end
               end
               CMD_SET: begin
                  if (r_rdata.ident == req_ff.target_id) begin
                     r_we     = 1'b1;
                     r_wdata  = rec_set;
                     state_in = ST_IDLE;
                  end else if (k_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     k_in     = k_p1;
                     state_in = ST_ORD;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SKIP: begin
            if (req_ff.now_ms > rec_ff.due
                && (17'(rec_ff.frame) + 17'd1) < 17'(rec_ff.total)) begin
               rec_in.due   = rec_ff.due + rec_ff.length;
               rec_in.frame = rec_ff.frame + 16'd1;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            r_we = 1'b1;
            if (rec_ff.frame >= rec_ff.total) begin
               f_we  = 1'b1;
               sp_in = sp_ff + CW'(1);
            end else begin
               o_we = 1'b1;
               w_in = w_ff + CW'(1);
            end
            if (k_last) begin
               count_in = w_in;
               state_in = ST_FLUSH;
            end else begin
               k_in     = k_p1;
               state_in = ST_ORD;
            end
         end
         ST_FLUSH: begin
            res_valid     = pend_valid_ff;
            res_data.last = 1'b1;
            if (!pend_valid_ff || res_ready) begin
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_ADD_POP: begin
            state_in = ST_ADD_TAKE;
         end
         ST_ADD_TAKE: begin
            slot_in  = f_rdata;
            sp_in    = sp_m1;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            r_we                        = 1'b1;
            r_wdata.ident               = id_ff;
            r_wdata.due                 = req_ff.now_ms + req_ff.init_delay;
            r_wdata.pause_left          = 32'd0;
            r_wdata.frame               = 16'd0;
            r_wdata.length              = req_ff.frame_length;
            r_wdata.total               = req_ff.frame_count;
            r_wdata.flags[FL_ACTIVE]    = 1'b1;
            r_wdata.flags[FL_SKIP]      = req_ff.skip_missed;
            r_wdata.flags[FL_FRAME]     = req_ff.has_frame_handler;
            r_wdata.flags[FL_START]     = req_ff.has_start_handler;
            r_wdata.flags[FL_END]       = req_ff.has_end_handler;
            o_we          = 1'b1;
            o_waddr       = count_ff[SW-1:0];
            count_in      = count_ff + CW'(1);
            pend_in       = '{KIND_ADD_OK, id_ff, 16'd0, HND_NORMAL, 1'b0};
            pend_valid_in = 1'b1;
            id_in         = id_ff + 16'd1;
            state_in      = ST_FLUSH;
         end
         ST_SHIFT_RD: begin
            o_raddr  = k_p1[SW-1:0];
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            o_we     = 1'b1;
            o_waddr  = k_ff[SW-1:0];
            o_wdata  = o_rdata;
            k_in     = k_p1;
            state_in = (k_p1 < count_ff) ? ST_SHIFT_RD : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         fresh_ff      <= '0;
         sp_ff         <= '0;
         id_ff         <= 16'd1;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fresh_ff      <= fresh_in;
         sp_ff         <= sp_in;
         id_ff         <= id_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      k_ff    <= k_in;
      w_ff    <= w_in;
      slot_ff <= slot_in;
      rec_ff  <= rec_in;
      n_ff    <= n_in;
      pend_ff <= pend_in;
   end

endmodule

// File: rtl/core/ftet_checker.sv
// Port checker for the frame timer event table, bound to the top level.
// Depends on ftet_pkg and frame_timer_event_table.
module ftet_port_checker
   import ftet_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [3:0]   rsp_tuser,
   input logic         rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result dropped or changed while stalled");

   a_add_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != KIND_FRAME |-> rsp_tlast)
      else $error("add result not marked last");

   a_add_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != KIND_FRAME
      |-> rsp_tdata[31:16] == 16'd0 && rsp_tuser[3:2] == HND_NORMAL)
      else $error("add result carries frame or handler");

   a_full_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_FULL |-> rsp_tdata[15:0] == 16'd0)
      else $error("rejected add carries an id");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

endmodule

bind frame_timer_event_table ftet_port_checker u_ftet_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
